@@ rtl/smm_pkg.sv @@
package smm_pkg;

	// list geometry
	localparam int LIST_DEPTH = 1024;
	localparam int KEY_BITS   = 32;
	localparam int ADDR_W     = $clog2(LIST_DEPTH);
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

	// port field widths
	localparam int POS_W      = 11;
	localparam int REQ_W      = 2;
	localparam int S_DATA_W   = 32;
	localparam int S_USER_W   = 3;
	localparam int M_DATA_W   = 16;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// request kinds
	localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
	localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

	// register index of key_signed
	localparam logic REG_KEY_SIGNED = 1'b0;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [CNT_W-1:0]    cnt_t;

endpackage

@@ rtl/smm_ram.sv @@
module smm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/sorted_membership_merge_unit.sv @@
// sorted membership merge unit
// tests each query key against a sorted reference list with a two-pointer walk
// input channel s_*: one word per request; tuser carries the request kind and
//   the run-start flag, tdata the key. appends must arrive in ascending order
//   (the block does not enforce it), a query returns one result word, clear empties the list
// output channel m_*: one word per query; tuser = is_member, tdata holds the
//   1-based match position (0 when there is no match)
// apb port: register 0 at byte address 0, bit 0 = key_signed (reset 1)
// append, clear and unused kinds give no word
// a query steps from fetch into compare while reference entries remain and ends
//   in fetch on a list already used up, else in compare on a match, on a greater
//   entry or when the walk runs off the end; no new request is taken until
//   the result is loaded. each walk step is one compare of the shared
//   comparator against one read of the reference ram, so a full sorted merge
//   costs about queries + entries steps
// the result word is loaded into an output register; the next request is
//   accepted while it waits. if the receiver stalls and a new result is ready
//   the sequencer parks it until the output register frees
// reset: list count and walk pointer go to zero, key_signed to 1. the ram is
//   not cleared; only entries below the fill count are ever compared
module sorted_membership_merge_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [smm_pkg::S_DATA_W-1:0]      s_tdata,  // [31:0] key
	input  logic [smm_pkg::S_USER_W-1:0]      s_tuser,  // [1:0] req_type, [2] run_start
	// master stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [smm_pkg::M_DATA_W-1:0]      m_tdata,  // [10:0] match_position, zero fill
	output logic                              m_tuser,  // [0] is_member
	// apb
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [smm_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [smm_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [smm_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);

	import smm_pkg::*;

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FETCH = 2'd1;
	localparam logic [1:0] ST_CMP   = 2'd2;
	localparam logic [1:0] ST_PARK  = 2'd3;

	logic [1:0]       state_q;
	logic             key_signed_q;
	cnt_t             count_q;
	cnt_t             ptr_q;
	key_t             query_q;
	logic             m_valid_q;
	logic             m_member_q;
	logic [POS_W-1:0] m_pos_q;
	logic             park_member_q;
	logic [POS_W-1:0] park_pos_q;

	logic             s_acc;
	logic [REQ_W-1:0] req;
	logic             run_start;
	key_t             key_in;
	logic             out_free;
	logic             cfg_wr;
	logic             m_load;

	cnt_t             ptr_inc;
	key_t             ref_rd;
	key_t             sign_flip;
	key_t             ord_ref;
	key_t             ord_query;
	logic             ref_less;
	logic             ref_equal;
	logic             ram_we;
	logic [ADDR_W-1:0] ram_raddr;

	// finish strobe for the walk, with its result
	logic             fin;
	logic             fin_member;
	logic [POS_W-1:0] fin_pos;

	assign req       = s_tuser[REQ_W-1:0];
	assign run_start = s_tuser[REQ_W];
	assign key_in    = s_tdata[KEY_BITS-1:0];

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	// a finished or parked result enters the output register
	assign m_load   = out_free && (fin || (state_q == ST_PARK));

	// apb: always ready, word-aligned decode on paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_KEY_SIGNED);
	assign prdata = (paddr[2] == REG_KEY_SIGNED) ?
			{{(APB_DATA_W-1){1'b0}}, key_signed_q} : '0;

	// reference store
	assign ram_we    = s_acc && (req == REQ_APPEND) && (count_q < cnt_t'(LIST_DEPTH));
	assign ptr_inc   = ptr_q + cnt_t'(1);
	// in compare the next entry is prefetched, so the walk steps without returning to fetch
	assign ram_raddr = (state_q == ST_CMP) ? ptr_inc[ADDR_W-1:0] : ptr_q[ADDR_W-1:0];

	smm_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(LIST_DEPTH)
	) u_ref_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(key_in),
		.raddr(ram_raddr),
		.rdata(ref_rd)
	);

	// shared comparator: flipping the top bit maps signed order onto unsigned
	assign sign_flip = {key_signed_q, {(KEY_BITS-1){1'b0}}};
	assign ord_ref   = ref_rd ^ sign_flip;
	assign ord_query = query_q ^ sign_flip;
	assign ref_less  = ord_ref < ord_query;
	assign ref_equal = ref_rd == query_q;

	always_comb begin
		fin        = 1'b0;
		fin_member = 1'b0;
		fin_pos    = '0;
		unique case (state_q)
			ST_FETCH: begin
				// list empty or used up
				fin = !(ptr_q < count_q);
			end
			ST_CMP: begin
				if (ref_equal) begin
					fin        = 1'b1;
					fin_member = 1'b1;
					fin_pos    = POS_W'(ptr_inc);
				end else if (ref_less) begin
					fin = !(ptr_inc < count_q);
				end else begin
					fin = 1'b1;
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			key_signed_q <= 1'b1;
			count_q      <= '0;
			ptr_q        <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr) begin
				key_signed_q <= pwdata[0];
			end
			if (m_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						priority if (req == REQ_APPEND) begin
							if (ram_we) begin
								count_q <= count_q + cnt_t'(1);
							end
						end else if (req == REQ_CLEAR) begin
							count_q <= '0;
							ptr_q   <= '0;
						end else if (req == REQ_QUERY) begin
							if (run_start) begin
								ptr_q <= '0;
							end
							state_q <= ST_FETCH;
						end else begin
							// unused kind is dropped
						end
					end
				end
				ST_FETCH, ST_CMP: begin
					if (state_q == ST_FETCH) begin
						if (!fin) begin
							state_q <= ST_CMP;
						end
					end else if (ref_equal || ref_less) begin
						// step past the entry, on a match as well
						ptr_q <= ptr_inc;
					end
					if (fin) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_PARK;
						end
					end
				end
				ST_PARK: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_acc && (req == REQ_QUERY)) begin
			query_q <= key_in;
		end
		if (fin) begin
			park_member_q <= fin_member;
			park_pos_q    <= fin_pos;
		end
		if (fin && out_free) begin
			m_member_q <= fin_member;
			m_pos_q    <= fin_pos;
		end else if ((state_q == ST_PARK) && out_free) begin
			m_member_q <= park_member_q;
			m_pos_q    <= park_pos_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_member_q;
	assign m_tdata  = {{(M_DATA_W-POS_W){1'b0}}, m_pos_q};

endmodule
